// File: sv/psd_pkg.sv
// Shared definitions for the point to segment distance pipeline.
// Holds the parameter defaults and the projection flag struct; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic t_zero;
        logic t_one;
    } t_proj_flags;

endpackage

`default_nettype wire

// File: sv/psd_front.sv
// Front end of the distance pipeline: differences, products, length and dot sums,
// and the clamp flags, over four register stages. Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_front #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output logic                         o_valid,
    output psd_pkg::t_proj_flags         o_flags,
    output logic [2*COORD_BITS:0]        o_dividend,
    output logic [2*COORD_BITS:0]        o_divisor,
    output logic signed [COORD_BITS-1:0] o_start_x,
    output logic signed [COORD_BITS-1:0] o_start_y,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS:0]   o_vec_x,
    output logic signed [COORD_BITS:0]   o_vec_y
);

    localparam int D  = COORD_BITS + 1;
    localparam int L  = 2 * COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int C  = COORD_BITS;

    logic                 r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [4*C-1:0]       r_s1_pass, r_s2_pass, r_s3_pass, r_s4_pass;
    logic signed [D-1:0]  r_s1_vx, r_s1_vy, r_s1_wx, r_s1_wy;
    logic signed [D-1:0]  r_s2_vx, r_s2_vy, r_s3_vx, r_s3_vy, r_s4_vx, r_s4_vy;
    logic signed [PW-1:0] r_s2_vxx, r_s2_vyy, r_s2_wvx, r_s2_wvy;
    logic [L-1:0]         r_s3_len;
    logic signed [PW-1:0] r_s3_dot;
    psd_pkg::t_proj_flags r_s4_flags;
    logic [L-1:0]         r_s4_dividend, r_s4_divisor;
    logic [L-1:0]         n_len;
    logic                 n_zero;

    assign n_len  = {1'b0, r_s2_vxx[2*C-1:0]} + {1'b0, r_s2_vyy[2*C-1:0]};
    assign n_zero = (r_s3_len == '0) || (r_s3_dot <= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pass <= {i_seg_start_x, i_seg_start_y, i_point_x, i_point_y};
            r_s1_vx   <= D'(i_seg_end_x) - D'(i_seg_start_x);
            r_s1_vy   <= D'(i_seg_end_y) - D'(i_seg_start_y);
            r_s1_wx   <= D'(i_point_x) - D'(i_seg_start_x);
            r_s1_wy   <= D'(i_point_y) - D'(i_seg_start_y);

            r_s2_pass <= r_s1_pass;
            r_s2_vx   <= r_s1_vx;
            r_s2_vy   <= r_s1_vy;
            r_s2_vxx  <= r_s1_vx * r_s1_vx;
            r_s2_vyy  <= r_s1_vy * r_s1_vy;
            r_s2_wvx  <= r_s1_wx * r_s1_vx;
            r_s2_wvy  <= r_s1_wy * r_s1_vy;

            r_s3_pass <= r_s2_pass;
            r_s3_vx   <= r_s2_vx;
            r_s3_vy   <= r_s2_vy;
            r_s3_len  <= n_len;
            r_s3_dot  <= r_s2_wvx + r_s2_wvy;

            r_s4_pass         <= r_s3_pass;
            r_s4_vx           <= r_s3_vx;
            r_s4_vy           <= r_s3_vy;
            r_s4_flags.t_zero <= n_zero;
            r_s4_flags.t_one  <= !n_zero && (r_s3_dot >= $signed({1'b0, r_s3_len}));
            r_s4_dividend     <= r_s3_dot[L-1:0];
            r_s4_divisor      <= r_s3_len;
        end
    end

    assign o_valid    = r_s4_valid;
    assign o_flags    = r_s4_flags;
    assign o_dividend = r_s4_dividend;
    assign o_divisor  = r_s4_divisor;
    assign o_start_x  = r_s4_pass[4*C-1:3*C];
    assign o_start_y  = r_s4_pass[3*C-1:2*C];
    assign o_point_x  = r_s4_pass[2*C-1:C];
    assign o_point_y  = r_s4_pass[C-1:0];
    assign o_vec_x    = r_s4_vx;
    assign o_vec_y    = r_s4_vy;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> !(r_s4_flags.t_zero && r_s4_flags.t_one))
        else $error("projection flags set together");

endmodule

`default_nettype wire

// File: sv/psd_div.sv
// Pipelined restoring divider producing one quotient bit per register stage.
// Carries the clamp flags and a side bus alongside; depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_div #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF,
    parameter int AUX_W           = 6 * psd_pkg::COORD_BITS_DEF + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  psd_pkg::t_proj_flags       i_flags,
    input  logic [2*COORD_BITS:0]      i_dividend,
    input  logic [2*COORD_BITS:0]      i_divisor,
    input  logic [AUX_W-1:0]           i_aux,
    output logic                       o_valid,
    output psd_pkg::t_proj_flags       o_flags,
    output logic [PARAM_FRAC_BITS-1:0] o_quo,
    output logic [AUX_W-1:0]           o_aux
);

    localparam int L = 2 * COORD_BITS + 1;
    localparam int F = PARAM_FRAC_BITS;

    for (genvar k = 0; k < F; k++) begin : g_step
        logic                 r_valid;
        psd_pkg::t_proj_flags r_flags;
        logic [L-1:0]         r_rem, r_div;
        logic [F-1:0]         r_quo;
        logic [AUX_W-1:0]     r_aux;
        logic                 p_valid;
        psd_pkg::t_proj_flags p_flags;
        logic [L-1:0]         p_rem, p_div;
        logic [F-1:0]         p_quo;
        logic [AUX_W-1:0]     p_aux;
        logic [L:0]           n_shift;
        logic                 n_ge;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_flags = i_flags;
            assign p_rem   = i_dividend;
            assign p_div   = i_divisor;
            assign p_quo   = '0;
            assign p_aux   = i_aux;
        end else begin : g_next
            assign p_valid = g_step[k-1].r_valid;
            assign p_flags = g_step[k-1].r_flags;
            assign p_rem   = g_step[k-1].r_rem;
            assign p_div   = g_step[k-1].r_div;
            assign p_quo   = g_step[k-1].r_quo;
            assign p_aux   = g_step[k-1].r_aux;
        end

        assign n_shift = {p_rem, 1'b0};
        assign n_ge    = n_shift >= {1'b0, p_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flags <= p_flags;
                r_div   <= p_div;
                r_aux   <= p_aux;
                r_quo   <= {p_quo[F-2:0], n_ge};
                if (n_ge) begin
                    r_rem <= L'(n_shift - {1'b0, p_div});
                end else begin
                    r_rem <= n_shift[L-1:0];
                end
            end
        end
    end

    assign o_valid = g_step[F-1].r_valid;
    assign o_flags = g_step[F-1].r_flags;
    assign o_quo   = g_step[F-1].r_quo;
    assign o_aux   = g_step[F-1].r_aux;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g_step[F-1].r_valid && !g_step[F-1].r_flags.t_zero && !g_step[F-1].r_flags.t_one)
            |-> (g_step[F-1].r_rem < g_step[F-1].r_div))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: sv/psd_back.sv
// Back end of the distance pipeline: clamped fraction times segment vector,
// rounding to the closest point, and the squared distance. Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_back #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  psd_pkg::t_proj_flags         i_flags,
    input  logic [PARAM_FRAC_BITS-1:0]   i_quo,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS:0]   i_vec_x,
    input  logic signed [COORD_BITS:0]   i_vec_y,
    output logic                         o_valid,
    output logic [2*COORD_BITS:0]        o_dist_sq,
    output logic signed [COORD_BITS-1:0] o_closest_x,
    output logic signed [COORD_BITS-1:0] o_closest_y
);

    localparam int C = COORD_BITS;
    localparam int F = PARAM_FRAC_BITS;
    localparam int P = C + F + 3;
    localparam int W = C + 3;
    localparam logic signed [P-1:0] HALF = P'(1) << (F - 1);

    logic                  r_b1_valid, r_b2_valid, r_b3_valid, r_b4_valid, r_b5_valid;
    logic                  r_b1_zero;
    logic signed [P-1:0]   r_b1_prod_x, r_b1_prod_y;
    logic signed [C-1:0]   r_b1_ax, r_b1_ay, r_b1_px, r_b1_py;
    logic signed [C-1:0]   r_b2_cx, r_b2_cy, r_b2_px, r_b2_py;
    logic signed [C-1:0]   r_b3_cx, r_b3_cy, r_b4_cx, r_b4_cy, r_b5_cx, r_b5_cy;
    logic signed [C:0]     r_b3_dx, r_b3_dy;
    logic signed [2*C+1:0] r_b4_sqx, r_b4_sqy;
    logic [2*C:0]          r_b5_dist;
    logic [F:0]            n_t;
    logic signed [P-1:0]   n_rnd_x, n_rnd_y;
    logic signed [W-1:0]   n_cx, n_cy;

    always_comb begin
        if (i_flags.t_zero) begin
            n_t = '0;
        end else if (i_flags.t_one) begin
            n_t = {1'b1, {F{1'b0}}};
        end else begin
            n_t = {1'b0, i_quo};
        end
    end

    assign n_rnd_x = r_b1_prod_x + HALF;
    assign n_rnd_y = r_b1_prod_y + HALF;
    assign n_cx    = W'(r_b1_ax) + W'(n_rnd_x >>> F);
    assign n_cy    = W'(r_b1_ay) + W'(n_rnd_y >>> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
            r_b5_valid <= 1'b0;
        end else if (i_en) begin
            r_b1_valid <= i_valid;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
            r_b5_valid <= r_b4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_zero   <= (n_t == '0);
            r_b1_prod_x <= i_vec_x * $signed({1'b0, n_t});
            r_b1_prod_y <= i_vec_y * $signed({1'b0, n_t});
            r_b1_ax     <= i_start_x;
            r_b1_ay     <= i_start_y;
            r_b1_px     <= i_point_x;
            r_b1_py     <= i_point_y;

            r_b2_cx <= n_cx[C-1:0];
            r_b2_cy <= n_cy[C-1:0];
            r_b2_px <= r_b1_px;
            r_b2_py <= r_b1_py;

            r_b3_cx <= r_b2_cx;
            r_b3_cy <= r_b2_cy;
            r_b3_dx <= (C+1)'(r_b2_px) - (C+1)'(r_b2_cx);
            r_b3_dy <= (C+1)'(r_b2_py) - (C+1)'(r_b2_cy);

            r_b4_cx  <= r_b3_cx;
            r_b4_cy  <= r_b3_cy;
            r_b4_sqx <= r_b3_dx * r_b3_dx;
            r_b4_sqy <= r_b3_dy * r_b3_dy;

            r_b5_cx   <= r_b4_cx;
            r_b5_cy   <= r_b4_cy;
            r_b5_dist <= {1'b0, r_b4_sqx[2*C-1:0]} + {1'b0, r_b4_sqy[2*C-1:0]};
        end
    end

    assign o_valid     = r_b5_valid;
    assign o_dist_sq   = r_b5_dist;
    assign o_closest_x = r_b5_cx;
    assign o_closest_y = r_b5_cy;

    a_zero_t_gives_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_b1_valid && r_b1_zero)
            |=> (r_b2_cx == $past(r_b1_ax)) && (r_b2_cy == $past(r_b1_ay)))
        else $error("zero fraction did not give the segment start");

endmodule

`default_nettype wire

// File: sv/point_segment_distance_core.sv
// An accepted word passes PARAM_FRAC_BITS + 9 register stages on its way to its result
// word: four front stages, one divider stage per fraction bit and five back stages.
// Throughput: one word per cycle while the result is not stalled.
// A stalled result freezes the whole pipeline until it is taken.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_core #(
    parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2*COORD_BITS:0]        o_dist_sq,
    output logic signed [COORD_BITS-1:0] o_closest_x,
    output logic signed [COORD_BITS-1:0] o_closest_y
);

    localparam int C     = COORD_BITS;
    localparam int AUX_W = 6 * COORD_BITS + 2;

    logic                       pipe_en;
    logic                       front_valid, div_valid;
    psd_pkg::t_proj_flags       front_flags, div_flags;
    logic [2*C:0]               front_dividend, front_divisor;
    logic signed [C-1:0]        front_ax, front_ay, front_px, front_py;
    logic signed [C:0]          front_vx, front_vy;
    logic [AUX_W-1:0]           front_aux, div_aux;
    logic [PARAM_FRAC_BITS-1:0] div_quo;
    logic signed [C-1:0]        div_ax, div_ay, div_px, div_py;
    logic signed [C:0]          div_vx, div_vy;

    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en;

    psd_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_valid      (i_valid),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_seg_start_x(i_seg_start_x),
        .i_seg_start_y(i_seg_start_y),
        .i_seg_end_x  (i_seg_end_x),
        .i_seg_end_y  (i_seg_end_y),
        .o_valid      (front_valid),
        .o_flags      (front_flags),
        .o_dividend   (front_dividend),
        .o_divisor    (front_divisor),
        .o_start_x    (front_ax),
        .o_start_y    (front_ay),
        .o_point_x    (front_px),
        .o_point_y    (front_py),
        .o_vec_x      (front_vx),
        .o_vec_y      (front_vy)
    );

    assign front_aux = {front_ax, front_ay, front_px, front_py, front_vx, front_vy};

    psd_div #(
        .COORD_BITS     (COORD_BITS),
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
        .AUX_W          (AUX_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (front_valid),
        .i_flags   (front_flags),
        .i_dividend(front_dividend),
        .i_divisor (front_divisor),
        .i_aux     (front_aux),
        .o_valid   (div_valid),
        .o_flags   (div_flags),
        .o_quo     (div_quo),
        .o_aux     (div_aux)
    );

    assign div_ax = div_aux[6*C+1:5*C+2];
    assign div_ay = div_aux[5*C+1:4*C+2];
    assign div_px = div_aux[4*C+1:3*C+2];
    assign div_py = div_aux[3*C+1:2*C+2];
    assign div_vx = div_aux[2*C+1:C+1];
    assign div_vy = div_aux[C:0];

    psd_back #(
        .COORD_BITS     (COORD_BITS),
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (div_valid),
        .i_flags    (div_flags),
        .i_quo      (div_quo),
        .i_start_x  (div_ax),
        .i_start_y  (div_ay),
        .i_point_x  (div_px),
        .i_point_y  (div_py),
        .i_vec_x    (div_vx),
        .i_vec_y    (div_vy),
        .o_valid    (o_valid),
        .o_dist_sq  (o_dist_sq),
        .o_closest_x(o_closest_x),
        .o_closest_y(o_closest_y)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output word was free");

endmodule

`default_nettype wire
